// ===== design/bscfc_pkg.sv =====
// ----------------------------------------------------------------------------
// bscfc_pkg
// Shared types and constants for the bitmap set/clear/find/count unit:
// store geometry, request codes and the input and result beat structs.
// ----------------------------------------------------------------------------
`default_nettype none

package bscfc_pkg;

    // Store geometry
    localparam int MAX_BITS   = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int WBIT_W     = $clog2(WORD_BITS);
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 11;
    localparam int PCNT_W     = WBIT_W + 1;

    // Request codes (anything above REQ_CLEAR_ALL acts as a query)
    localparam logic [2:0] REQ_QUERY     = 3'd0;
    localparam logic [2:0] REQ_SET_RANGE = 3'd1;
    localparam logic [2:0] REQ_CLR_RANGE = 3'd2;
    localparam logic [2:0] REQ_TOGGLE    = 3'd3;
    localparam logic [2:0] REQ_CLEAR_ALL = 3'd4;

    // Configuration reset value
    localparam logic [CNT_W-1:0] BITS_IN_USE_RST = CNT_W'(MAX_BITS);

    typedef struct packed {
        logic [2:0]       req_type;
        logic [IDX_W-1:0] bit_index;
        logic [LEN_W-1:0] range_length;
    } in_item_t;

    typedef struct packed {
        logic             bit_value;
        logic             set_found;
        logic [IDX_W-1:0] first_set_index;
        logic             zero_found;
        logic [IDX_W-1:0] first_zero_index;
        logic [CNT_W-1:0] set_count;
        logic             range_clipped;
    } out_item_t;

endpackage

`default_nettype wire

// ===== design/bitmap_set_clear_find_count_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_count_unit
// Each request makes one pass over the store: the words are read in turn,
// each word is modified and written back while the next one is read, and
// the result register is loaded once the pass ends and the output is free.
// No new request is taken while a pass is running or a result is waiting.
// Reset: store reads as all zero (per-word valid flags), bits_in_use = 1024.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_set_clear_find_count_unit
    import bscfc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,

    input  wire logic             cfg_wr_en,
    input  wire logic [CNT_W-1:0] cfg_wr_data,

    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire in_item_t         in_data,

    output logic                  out_valid,
    input  wire logic             out_ready,
    output out_item_t             out_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

    // Control and accumulator registers
    state_t             state_reg;
    logic [WADDR_W:0]   rd_cnt_reg;
    logic               proc_valid_reg;
    logic [WADDR_W-1:0] proc_addr_reg;
    logic [CNT_W-1:0]   bits_in_use_reg;
    logic [2:0]         req_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   range_end_reg;
    logic               clipped_reg;
    logic               sf_reg;
    logic               zf_reg;
    logic [IDX_W-1:0]   fs_reg;
    logic [IDX_W-1:0]   fz_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               bv_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // Store, per-word valid flags and read port
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] word_valid_reg;
    logic [WORD_BITS-1:0] rdata_reg;
    logic                 rvalid_reg;

    logic                 accept;
    logic                 out_free;
    logic                 rd_issue;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 last_word;
    logic [CNT_W-1:0]     limit;
    logic [IDX_W+1:0]     range_sum;
    logic                 range_req;
    logic                 clipped_next;
    logic [CNT_W-1:0]     range_end_next;

    logic [WORD_BITS-1:0] word_old;
    logic [WORD_BITS-1:0] word_new;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] set_bits;
    logic [WORD_BITS-1:0] zero_bits;
    logic [WBIT_W-1:0]    set_pos;
    logic [WBIT_W-1:0]    zero_pos;
    logic [PCNT_W-1:0]    word_pcnt;

    // Handshake
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_DONE) && out_free);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Read sequencing over the store
    assign rd_issue  = (state_reg == ST_RUN) && !rd_cnt_reg[WADDR_W];
    assign rd_addr   = rd_cnt_reg[WADDR_W-1:0];
    assign last_word = proc_valid_reg && (proc_addr_reg == WADDR_W'(NUM_WORDS - 1));

    // Clamp the active bit count to capacity
    assign limit = (bits_in_use_reg > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : bits_in_use_reg;

    // Range end and clipping, worked out at accept
    assign range_sum      = {2'b00, in_data.bit_index} + {1'b0, in_data.range_length};
    assign range_req      = (in_data.req_type == REQ_SET_RANGE) ||
                            (in_data.req_type == REQ_CLR_RANGE);
    assign clipped_next   = range_req && (range_sum > (IDX_W+2)'(MAX_BITS));
    assign range_end_next = (range_sum > (IDX_W+2)'(MAX_BITS)) ? CNT_W'(MAX_BITS)
                                                               : range_sum[CNT_W-1:0];

    // Modify the word in flight and scan it for find and count
    always_comb
    begin
        logic [IDX_W-1:0] pos;
        logic             in_rng;
        word_old  = rvalid_reg ? rdata_reg : '0;
        word_new  = word_old;
        lim_mask  = '0;
        set_pos   = '0;
        zero_pos  = '0;
        word_pcnt = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pos    = {proc_addr_reg, WBIT_W'(j)};
            in_rng = (pos >= idx_reg) && ({1'b0, pos} < range_end_reg);
            unique case (req_reg)
                REQ_SET_RANGE: if (in_rng) word_new[j] = 1'b1;
                REQ_CLR_RANGE: if (in_rng) word_new[j] = 1'b0;
                REQ_TOGGLE:    if (pos == idx_reg) word_new[j] = !word_old[j];
                REQ_CLEAR_ALL: word_new[j] = 1'b0;
                default:       word_new[j] = word_old[j];
            endcase
            lim_mask[j] = ({1'b0, pos} < limit);
        end
        set_bits  = word_new & lim_mask;
        zero_bits = ~word_new & lim_mask;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (set_bits[j])  set_pos  = WBIT_W'(j);
            if (zero_bits[j]) zero_pos = WBIT_W'(j);
        end
        for (int j = 0; j < WORD_BITS; j++)
        begin
            word_pcnt = word_pcnt + PCNT_W'(set_bits[j]);
        end
    end

    // Store: registered read, write-back of the modified word
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (proc_valid_reg)
        begin
            mem[proc_addr_reg] <= word_new;
        end
    end

    // Sequencer, accumulators, configuration and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_cnt_reg      <= '0;
            proc_valid_reg  <= 1'b0;
            proc_addr_reg   <= '0;
            bits_in_use_reg <= BITS_IN_USE_RST;
            word_valid_reg  <= '0;
            rvalid_reg      <= 1'b0;
            req_reg         <= REQ_QUERY;
            idx_reg         <= '0;
            range_end_reg   <= '0;
            clipped_reg     <= 1'b0;
            sf_reg          <= 1'b0;
            zf_reg          <= 1'b0;
            fs_reg          <= '0;
            fz_reg          <= '0;
            cnt_reg         <= '0;
            bv_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            // Take configuration writes
            if (cfg_wr_en)
            begin
                bits_in_use_reg <= cfg_wr_data;
            end

            // Drop the result once taken, unless the next one replaces it
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            // Advance the read pointer and the processing stage
            proc_valid_reg <= rd_issue;
            proc_addr_reg  <= rd_addr;
            if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
                rvalid_reg <= word_valid_reg[rd_addr];
            end

            // Accumulate find and count over the words of the pass
            if (proc_valid_reg)
            begin
                word_valid_reg[proc_addr_reg] <= 1'b1;
                cnt_reg <= cnt_reg + CNT_W'(word_pcnt);
                if (!sf_reg && (set_bits != '0))
                begin
                    sf_reg <= 1'b1;
                    fs_reg <= {proc_addr_reg, set_pos};
                end
                if (!zf_reg && (zero_bits != '0))
                begin
                    zf_reg <= 1'b1;
                    fz_reg <= {proc_addr_reg, zero_pos};
                end
                if (proc_addr_reg == idx_reg[IDX_W-1:WBIT_W])
                begin
                    bv_reg <= word_new[idx_reg[WBIT_W-1:0]];
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (last_word)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    // Load the result beat once the output register is free
                    if (out_free)
                    begin
                        out_valid_reg                 <= 1'b1;
                        out_data_reg.bit_value        <= bv_reg;
                        out_data_reg.set_found        <= sf_reg;
                        out_data_reg.first_set_index  <= fs_reg;
                        out_data_reg.zero_found       <= zf_reg;
                        out_data_reg.first_zero_index <= fz_reg;
                        out_data_reg.set_count        <= cnt_reg;
                        out_data_reg.range_clipped    <= clipped_reg;
                        state_reg                     <= accept ? ST_RUN : ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Latch a new request and start its pass
            if (accept)
            begin
                rd_cnt_reg    <= '0;
                req_reg       <= in_data.req_type;
                idx_reg       <= in_data.bit_index;
                range_end_reg <= range_end_next;
                clipped_reg   <= clipped_next;
                sf_reg        <= 1'b0;
                zf_reg        <= 1'b0;
                fs_reg        <= '0;
                fz_reg        <= '0;
                cnt_reg       <= '0;
                bv_reg        <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // A word is only processed during a pass
    a_proc_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        proc_valid_reg |-> (state_reg == ST_RUN))
        else $error("word processed outside a pass");

    // A new result only follows the end of a pass
    a_result_after_pass: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_DONE))
        else $error("result loaded without a finished pass");

    // No request is taken while a pass is running
    a_no_accept_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !in_ready)
        else $error("request taken during a pass");

    // Count never exceeds capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.set_count <= CNT_W'(MAX_BITS)))
        else $error("set count beyond capacity");

    // An empty count reports no set bit
    a_empty_no_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.set_count == '0)) |-> !out_data_reg.set_found)
        else $error("set bit found with zero count");
`endif

endmodule

`default_nettype wire
